// ===== sv/two_level_ready_queue_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; files that assert include it by name.
`ifndef TWO_LEVEL_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define TWO_LEVEL_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TRLQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies the consequent in the cycle after.
`define TRLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/trlq_pkg.sv =====
// Shared types and constants of the two-level ready queue scheduler.
// No dependencies.
package trlq_pkg;

  localparam int PID_W     = 8;
  localparam int QUANTUM_W = 16;
  localparam int SHARE_W   = 7;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd100;
  localparam logic [SHARE_W-1:0]   SHARE_RESET   = 7'd70;

  // configuration register indexes
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_SHARE   = 1'b1;

  // input opcodes
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_WAKE     = 1'b1;

  // exit states of a returning process
  localparam logic [1:0] EXIT_READY    = 2'd0;
  localparam logic [1:0] EXIT_BLOCKED  = 2'd1;
  localparam logic [1:0] EXIT_FINISHED = 2'd2;
  localparam logic [1:0] EXIT_INVALID  = 2'd3;

  // per-cycle operation on one ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_op_t;

  // ring status seen by the controller
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ===== sv/trlq_ring.sv =====
// One FIFO ring of pids: storage memory, head pointer and fill count.
// Depends on trlq_pkg and the assertion macro header.
`include "two_level_ready_queue_scheduler_core_defines.svh"

module trlq_ring #(
  parameter int QUEUE_DEPTH = 16,
  localparam int HW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int SW = HW + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  trlq_pkg::ring_op_t         op,
  input  logic [trlq_pkg::PID_W-1:0] push_data,
  output trlq_pkg::ring_stat_t       stat,
  output logic [trlq_pkg::PID_W-1:0] pop_data
);

  logic [trlq_pkg::PID_W-1:0] mem [QUEUE_DEPTH];
  logic [trlq_pkg::PID_W-1:0] mem_q;
  logic [trlq_pkg::PID_W-1:0] fwd_data;
  logic                       fwd;
  logic [HW-1:0]              head;
  logic [HW-1:0]              head_next;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [SW-1:0]              wsum;
  logic [HW-1:0]              wptr;

  // tail slot: head plus count, wrapped once
  assign wsum = SW'(head) + SW'(count);
  assign wptr = (wsum >= SW'(QUEUE_DEPTH)) ? HW'(wsum - SW'(QUEUE_DEPTH)) : HW'(wsum);

  assign head_next  = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
  assign count_next = count + CW'(op.push) - CW'(op.pop);

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(QUEUE_DEPTH));

  // pointers and forward flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      fwd   <= 1'b0;
    end else begin
      count <= count_next;
      if (op.pop) begin
        head <= head_next;
        fwd  <= stat.empty;
      end
    end
  end

  // storage; a pop on an empty ring takes the word pushed in the same cycle
  always_ff @(posedge clk) begin
    if (op.push) mem[wptr] <= push_data;
    if (op.pop) begin
      mem_q    <= mem[head];
      fwd_data <= push_data;
    end
  end

  assign pop_data = fwd ? fwd_data : mem_q;

  `TRLQ_ASSERT(a_count_max, count <= CW'(QUEUE_DEPTH), "ring count beyond depth")
  `TRLQ_ASSERT(a_no_pop_empty, !op.pop || !stat.empty || op.push, "pop from empty ring")
  `TRLQ_ASSERT_NEXT(a_push_count, op.push && !op.pop, count == $past(count) + CW'(1),
                    "push did not raise count")

endmodule

// ===== sv/trlq_tag_mem.sv =====
// Per-pid level tag memory, one bit per pid, with a clearing pass after reset.
// Depends on nothing outside this file.
module trlq_tag_mem #(
  parameter int PID_COUNT = 256,
  localparam int TW = $clog2(PID_COUNT)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [TW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [TW-1:0] rd_addr,
  output logic          rd_data,
  output logic          busy
);

  logic          mem [PID_COUNT];
  logic [TW-1:0] clr_idx;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == TW'(PID_COUNT - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + TW'(1);
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/two_level_ready_queue_scheduler_core.sv =====
// Two-level ready queue scheduler: fast and slow pid rings plus a level tag memory.
// Depends on trlq_pkg, trlq_ring, trlq_tag_mem and the assertion macro header.
//
// Use: input words (opcode, has_current, pid, exit_state, time_used, chance)
// enter on in_valid/in_stall; one result word per input leaves on
// out_valid/out_stall. A schedule call reclassifies and may requeue the
// returning process, then pops the preferred ring (chance below the share
// picks the fast ring) with fallback to the other. A wake word appends the
// pid to the ring named by its stored tag.
// An accepted input moves the block to ST_FINISH, where its result loads into the
// output register once that is free. No new word is taken before then, since the
// queue and tag memories have registered reads (access on accept, data and wake
// push in ST_FINISH).
// Reset: rings empty, quantum 100, share 70. The tag memory is then cleared one pid
// a cycle with in_stall high; configuration writes are taken during the sweep.
// Stall: a held result keeps the output register; the block may take one more word
// and then waits in ST_FINISH until the register frees.
// Configuration: cfg_we writes cfg_data to register cfg_index. The user writes only
// while idle; the block does not enforce it.
`include "two_level_ready_queue_scheduler_core_defines.svh"

module two_level_ready_queue_scheduler_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_COUNT   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic        has_current,
  input  logic [7:0]  pid,
  input  logic [1:0]  exit_state,
  input  logic [15:0] time_used,
  input  logic [6:0]  chance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        selected_valid,
  output logic [7:0]  selected_pid,
  output logic        bad_state,
  output logic        overflow
);

  localparam int TW = $clog2(PID_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_FINISH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [trlq_pkg::QUANTUM_W-1:0] quantum;
  logic [trlq_pkg::SHARE_W-1:0]   share;

  // item held from accept into ST_FINISH
  logic                       wake_q;
  logic [trlq_pkg::PID_W-1:0] pid_q;
  logic                       sel_valid_q;
  logic                       sel_slow_q;
  logic                       bad_q;
  logic                       ovf_q;

  trlq_pkg::ring_op_t   fast_op;
  trlq_pkg::ring_op_t   slow_op;
  trlq_pkg::ring_stat_t fast_stat;
  trlq_pkg::ring_stat_t slow_stat;
  logic [trlq_pkg::PID_W-1:0] push_data;
  logic [trlq_pkg::PID_W-1:0] fast_pop_data;
  logic [trlq_pkg::PID_W-1:0] slow_pop_data;

  logic          tag_wr_en;
  logic          tag_wr_data;
  logic          tag_rd_en;
  logic          tag_rd_data;
  logic          tag_busy;
  logic [TW-1:0] tag_idx;

  logic accept;
  logic out_free;
  logic finish_go;
  logic is_sched;
  logic lvl_slow;
  logic want_push;
  logic push_fast_a;
  logic push_slow_a;
  logic ne_fast;
  logic ne_slow;
  logic pref_fast;
  logic pop_fast;
  logic pop_slow;
  logic wake_fast;
  logic wake_slow;
  logic [31:0] pid_rem;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE) || tag_busy;
  assign out_free  = !out_valid || !out_stall;
  assign finish_go = (state == ST_FINISH) && out_free;
  assign is_sched  = (opcode == trlq_pkg::OP_SCHEDULE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= trlq_pkg::QUANTUM_RESET;
      share   <= trlq_pkg::SHARE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trlq_pkg::REG_QUANTUM: quantum <= cfg_data;
        trlq_pkg::REG_SHARE:   share   <= cfg_data[trlq_pkg::SHARE_W-1:0];
        default:               quantum <= quantum;
      endcase
    end
  end

  // pid modulo PID_COUNT by restoring subtraction, eight steps
  always_comb begin
    pid_rem = {24'd0, pid};
    for (int k = 7; k >= 0; k--) begin
      if (pid_rem >= (32'(PID_COUNT) << k)) pid_rem = pid_rem - (32'(PID_COUNT) << k);
    end
  end
  assign tag_idx = pid_rem[TW-1:0];

  // accept step of a schedule call: classify, requeue, choose a ring
  assign lvl_slow    = time_used > (quantum >> 1);
  assign want_push   = accept && is_sched && has_current && (exit_state == trlq_pkg::EXIT_READY);
  assign push_fast_a = want_push && !lvl_slow && !fast_stat.full;
  assign push_slow_a = want_push && lvl_slow && !slow_stat.full;
  assign ne_fast     = !fast_stat.empty || push_fast_a;
  assign ne_slow     = !slow_stat.empty || push_slow_a;
  assign pref_fast   = chance < share;
  assign pop_fast    = accept && is_sched && ne_fast && (pref_fast || !ne_slow);
  assign pop_slow    = accept && is_sched && ne_slow && !(pref_fast && ne_fast);

  // ST_FINISH step of a wake: push by the stored tag
  assign wake_fast = finish_go && wake_q && !tag_rd_data && !fast_stat.full;
  assign wake_slow = finish_go && wake_q && tag_rd_data && !slow_stat.full;

  assign fast_op.push = push_fast_a || wake_fast;
  assign fast_op.pop  = pop_fast;
  assign slow_op.push = push_slow_a || wake_slow;
  assign slow_op.pop  = pop_slow;
  assign push_data    = accept ? pid : pid_q;

  // tag memory access
  assign tag_wr_en   = accept && is_sched && has_current;
  assign tag_wr_data = (exit_state == trlq_pkg::EXIT_FINISHED) ? 1'b0 : lvl_slow;
  assign tag_rd_en   = accept && !is_sched;

  // control state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      wake_q      <= !is_sched;
      pid_q       <= pid;
      sel_valid_q <= pop_fast || pop_slow;
      sel_slow_q  <= pop_slow;
      bad_q       <= is_sched && has_current && (exit_state == trlq_pkg::EXIT_INVALID);
      ovf_q       <= want_push && (lvl_slow ? slow_stat.full : fast_stat.full);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      if (wake_q) begin
        selected_valid <= 1'b0;
        selected_pid   <= '0;
        bad_state      <= 1'b0;
        overflow       <= tag_rd_data ? slow_stat.full : fast_stat.full;
      end else begin
        selected_valid <= sel_valid_q;
        selected_pid   <= !sel_valid_q ? '0 : (sel_slow_q ? slow_pop_data : fast_pop_data);
        bad_state      <= bad_q;
        overflow       <= ovf_q;
      end
    end
  end

  trlq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fast_ring (
    .clk       (clk),
    .rst       (rst),
    .op        (fast_op),
    .push_data (push_data),
    .stat      (fast_stat),
    .pop_data  (fast_pop_data)
  );

  trlq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_slow_ring (
    .clk       (clk),
    .rst       (rst),
    .op        (slow_op),
    .push_data (push_data),
    .stat      (slow_stat),
    .pop_data  (slow_pop_data)
  );

  trlq_tag_mem #(.PID_COUNT(PID_COUNT)) u_tag_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_idx),
    .wr_data (tag_wr_data),
    .rd_en   (tag_rd_en),
    .rd_addr (tag_idx),
    .rd_data (tag_rd_data),
    .busy    (tag_busy)
  );

  `TRLQ_ASSERT_NEXT(a_accept_finish, accept, state == ST_FINISH, "no second cycle after accept")
  `TRLQ_ASSERT(a_rise_from_finish, !$rose(out_valid) || $past(state == ST_FINISH),
               "result word without a finished item")
  `TRLQ_ASSERT(a_single_pop, !(fast_op.pop && slow_op.pop), "both rings popped at once")

endmodule

// ===== bench/ready_queue_checker.sv =====
// Checker for the two-level ready queue scheduler: watches the input, output and config ports.
// Predicts one result word per accepted input word and compares it field by field.
// Depends on trlq_pkg for the opcode, exit state and register index codes.
module ready_queue_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_COUNT   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic        has_current,
  input  logic [7:0]  pid,
  input  logic [1:0]  exit_state,
  input  logic [15:0] time_used,
  input  logic [6:0]  chance,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        selected_valid,
  input  logic [7:0]  selected_pid,
  input  logic        bad_state,
  input  logic        overflow,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          picks_seen,
  output int          drops_seen,
  output int          bad_seen
);

  typedef struct packed {
    logic       sel_valid;
    logic [7:0] sel_pid;
    logic       bad;
    logic       ovf;
  } pick_t;

  // expected result words, oldest first
  pick_t expected_picks[$];

  // shadow copy of the rings, tags and registers
  logic [7:0]  fast_ring [QUEUE_DEPTH];
  logic [7:0]  slow_ring [QUEUE_DEPTH];
  int          fast_head, fast_count, slow_head, slow_count;
  logic        level_of [PID_COUNT];
  logic [15:0] quantum_q;
  logic [6:0]  share_q;

  // append a pid to a level's ring; returns 1 when the ring is full and the pid is dropped
  function automatic logic enqueue_pid(input logic lvl, input logic [7:0] p);
    if (lvl) begin
      if (slow_count >= QUEUE_DEPTH) return 1'b1;
      slow_ring[(slow_head + slow_count) % QUEUE_DEPTH] = p;
      slow_count++;
    end else begin
      if (fast_count >= QUEUE_DEPTH) return 1'b1;
      fast_ring[(fast_head + fast_count) % QUEUE_DEPTH] = p;
      fast_count++;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] dequeue_pid(input logic lvl);
    logic [7:0] v;
    if (lvl) begin
      v = slow_ring[slow_head];
      slow_head = (slow_head + 1) % QUEUE_DEPTH;
      slow_count--;
    end else begin
      v = fast_ring[fast_head];
      fast_head = (fast_head + 1) % QUEUE_DEPTH;
      fast_count--;
    end
    return v;
  endfunction

  // next state and result word for one input word
  function automatic pick_t predict_word(input logic op, input logic hc, input logic [7:0] p,
                                         input logic [1:0] st, input logic [15:0] used,
                                         input logic [6:0] ch);
    pick_t r;
    logic  lvl;
    logic  take_fast;
    int    idx;
    r   = '0;
    idx = p % PID_COUNT;
    if (op == trlq_pkg::OP_WAKE) begin
      r.ovf = enqueue_pid(level_of[idx], p);
    end else begin
      if (hc) begin
        if (st == trlq_pkg::EXIT_FINISHED) begin
          level_of[idx] = 1'b0;
        end else begin
          lvl = (used > (quantum_q >> 1));
          level_of[idx] = lvl;
          if (st == trlq_pkg::EXIT_READY) r.ovf = enqueue_pid(lvl, p);
          else if (st == trlq_pkg::EXIT_INVALID) r.bad = 1'b1;
        end
      end
      // preferred ring first, the other one as fallback
      if (fast_count != 0 || slow_count != 0) begin
        take_fast = (ch < share_q) ? (fast_count != 0) : (slow_count == 0);
        r.sel_pid   = dequeue_pid(!take_fast);
        r.sel_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 30)
      $display("checker: result %0d field %s got %0d want %0d", results_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      expected_picks.delete();
      fast_head  = 0;
      fast_count = 0;
      slow_head  = 0;
      slow_count = 0;
      foreach (level_of[i]) level_of[i] = 1'b0;
      quantum_q = trlq_pkg::QUANTUM_RESET;
      share_q   = trlq_pkg::SHARE_RESET;
      pending  <= 0;
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          trlq_pkg::REG_QUANTUM: quantum_q = cfg_data;
          trlq_pkg::REG_SHARE:   share_q   = cfg_data[6:0];
          default:               quantum_q = quantum_q;
        endcase
      end
      // compare first so a stray result never meets a word accepted at this edge
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("out_valid", 1, 0);
        end else begin
          want = expected_picks.pop_front();
          if (selected_valid !== want.sel_valid)
            report_mismatch("selected_valid", selected_valid, want.sel_valid);
          if (selected_pid !== want.sel_pid)
            report_mismatch("selected_pid", selected_pid, want.sel_pid);
          if (bad_state !== want.bad)
            report_mismatch("bad_state", bad_state, want.bad);
          if (overflow !== want.ovf)
            report_mismatch("overflow", overflow, want.ovf);
          results_seen++;
          picks_seen += want.sel_valid;
          drops_seen += want.ovf;
          bad_seen   += want.bad;
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_picks.push_back(predict_word(opcode, has_current, pid, exit_state,
                                              time_used, chance));
      pending <= expected_picks.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the scheduler bench: clock, reset, stimulus and the verdict.
// Depends on trlq_pkg, two_level_ready_queue_scheduler_core and ready_queue_checker.
module testbench;

  localparam int SEGMENTS  = 12;
  localparam int SEG_WORDS = 100;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic        cfg_index   = trlq_pkg::REG_QUANTUM;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        opcode      = trlq_pkg::OP_SCHEDULE;
  logic        has_current = 1'b0;
  logic [7:0]  pid         = '0;
  logic [1:0]  exit_state  = trlq_pkg::EXIT_READY;
  logic [15:0] time_used   = '0;
  logic [6:0]  chance      = '0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        selected_valid;
  logic [7:0]  selected_pid;
  logic        bad_state;
  logic        overflow;

  int          errors, pending, results_seen, picks_seen, drops_seen, bad_seen;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          words_sent = 0;
  int          settings_used = 1;
  logic [15:0] cur_quantum = trlq_pkg::QUANTUM_RESET;

  two_level_ready_queue_scheduler_core u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .opcode, .has_current,
    .pid, .exit_state, .time_used, .chance, .out_valid, .out_stall, .selected_valid,
    .selected_pid, .bad_state, .overflow
  );

  ready_queue_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .opcode, .has_current,
    .pid, .exit_state, .time_used, .chance, .out_valid, .out_stall, .selected_valid,
    .selected_pid, .bad_state, .overflow, .errors, .pending, .results_seen, .picks_seen,
    .drops_seen, .bad_seen
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  // offer one word, with random idle cycles first, and hold it until taken
  task automatic send_word(input logic op, input logic hc, input logic [7:0] p,
                           input logic [1:0] st, input logic [15:0] used, input logic [6:0] ch);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    has_current <= hc;
    pid         <= p;
    exit_state  <= st;
    time_used   <= used;
    chance      <= ch;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and wait until every result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers on back-to-back edges
  task automatic set_config(input logic [15:0] q, input logic [15:0] s);
    cfg_we    <= 1'b1;
    cfg_index <= trlq_pkg::REG_QUANTUM;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= trlq_pkg::REG_SHARE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_quantum  = q;
    settings_used++;
  endtask

  // random word; time used clusters around the level boundary
  task automatic random_word(input int wake_pct);
    logic        op, hc;
    logic [7:0]  p;
    logic [1:0]  st;
    logic [15:0] used, half;
    logic [6:0]  ch;
    int          r;
    op   = ($urandom_range(99) < wake_pct) ? trlq_pkg::OP_WAKE : trlq_pkg::OP_SCHEDULE;
    hc   = ($urandom_range(99) < 80);
    p    = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    r    = $urandom_range(99);
    st   = (r < 55) ? trlq_pkg::EXIT_READY : (r < 75) ? trlq_pkg::EXIT_BLOCKED
         : (r < 90) ? trlq_pkg::EXIT_FINISHED : trlq_pkg::EXIT_INVALID;
    half = cur_quantum >> 1;
    case ($urandom_range(5))
      0: used = half;
      1: used = half + 16'd1;
      2: used = half - 16'd1;
      3: used = 16'd0;
      4: used = 16'hFFFF;
      default: used = 16'($urandom_range(65535));
    endcase
    ch = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
    send_word(op, hc, p, st, used, ch);
  endtask

  initial begin
    logic [15:0] q_table [5] = '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd20};
    logic [15:0] s_table [5] = '{16'd70, 16'd0, 16'd100, 16'd127, 16'd50};
    int          wake_mix [3] = '{25, 45, 65};
    repeat (10) @(posedge clk);
    rst       <= 1'b0;
    send_idle  = 18;
    recv_idle <= 74;

    // directed part at the reset register values (quantum 100, share 70)
    send_word(trlq_pkg::OP_SCHEDULE, 1'b0, 8'd0, trlq_pkg::EXIT_READY, 16'd0, 7'd0); // both empty
    send_word(trlq_pkg::OP_WAKE, 1'b1, 8'd0, trlq_pkg::EXIT_INVALID, 16'hFFFF, 7'd127);
    send_word(trlq_pkg::OP_WAKE, 1'b0, 8'd255, trlq_pkg::EXIT_READY, 16'd0, 7'd0);
    // half: fast level
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd7, trlq_pkg::EXIT_READY, 16'd50, 7'd99);
    // above half: slow
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd8, trlq_pkg::EXIT_READY, 16'd51, 7'd69);
    // blocked, tag slow
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd9, trlq_pkg::EXIT_BLOCKED, 16'hFFFF, 7'd70);
    // wake into slow
    send_word(trlq_pkg::OP_WAKE, 1'b0, 8'd9, trlq_pkg::EXIT_READY, 16'd0, 7'd0);
    // tag cleared
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd9, trlq_pkg::EXIT_FINISHED, 16'hFFFF, 7'd0);
    // bad exit state
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd11, trlq_pkg::EXIT_INVALID, 16'd0, 7'd127);
    send_word(trlq_pkg::OP_SCHEDULE, 1'b0, 8'd0, trlq_pkg::EXIT_READY, 16'd0, 7'd50);
    // fill the fast ring, then push into it while full
    for (int k = 1; k <= 17; k++)
      send_word(trlq_pkg::OP_WAKE, 1'b0, 8'(k), trlq_pkg::EXIT_READY, 16'd0, 7'd0);
    send_word(trlq_pkg::OP_SCHEDULE, 1'b1, 8'd200, trlq_pkg::EXIT_READY, 16'd0, 7'd0);
    wait_drained();

    // random part: one register setting per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle  = 74;
        recv_idle <= 18;
      end else if (seg == 8) begin
        send_idle  = 0;
        recv_idle <= 0;
      end
      if (seg < 5) set_config(q_table[seg], s_table[seg]);
      else set_config(16'($urandom_range(65535)), 16'($urandom_range(100)));
      for (int n = 0; n < SEG_WORDS; n++) random_word(wake_mix[seg % 3]);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("run: %0d words over %0d register settings, %0d results checked",
             words_sent, settings_used, results_seen);
    $display("run: %0d picks, %0d dropped pushes, %0d bad exit states",
             picks_seen, drops_seen, bad_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
